// ===== rtl/core/rtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtm_pkg;

  localparam int NumSubflows  = 4;
  localparam int TableDepth   = 16;
  localparam int CleanupCount = 64;
  localparam int PortRegs     = 4;
  localparam int IdxW         = $clog2(TableDepth);
  localparam int SfW          = 2;

  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [3:0]  IpVersion = 4'h4;
  localparam logic [7:0]  ProtoTcp  = 8'd6;

  typedef enum logic [2:0] {
    ST_MALFORMED = 3'd0,
    ST_NOT_PROXY = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_DOWN_SKIP = 3'd3,
    ST_DOWN_REC  = 3'd4,
    ST_UP_SKIP   = 3'd5,
    ST_RTT_UPD   = 3'd6,
    ST_FULL      = 3'd7
  } rtm_status_e;

  typedef enum logic [7:0] {
    REG_PROXY_PORT = 8'd0,
    REG_ACTIVE_SF  = 8'd1,
    REG_PORT_A     = 8'd2,
    REG_PORT_B     = 8'd3,
    REG_PORT_C     = 8'd4,
    REG_PORT_D     = 8'd5,
    REG_CLN_AGE    = 8'd6,
    REG_RTT_GAP    = 8'd7
  } rtm_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PARSE,
    S_WALK
  } rtm_state_e;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] ether_kind;
    logic [7:0]  ip_ver_ihl;
    logic [15:0] ip_total_len;
    logic [7:0]  ip_proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_offset_byte;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [47:0] now_time;
  } rtm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  subflow;
    logic [47:0] rtt_sample;
    logic [47:0] smoothed_rtt;
    logic [47:0] payload_total;
  } rtm_out_t;

  // search word walking down the cell row
  typedef struct packed {
    logic            vld;
    logic            cln;
    logic [SfW-1:0]  sf;
    logic [31:0]     key;
    logic [47:0]     now;
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [47:0]     hit_time;
    logic            free;
    logic [IdxW-1:0] free_idx;
  } rtm_tok_t;

  // entry update broadcast to all cells
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [IdxW-1:0] idx;
    logic [SfW-1:0]  sf;
    logic [31:0]     seq;
    logic [47:0]     time_v;
  } rtm_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcp_subflow_rtt_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// frames that touch no table get their result from the parse state; downlink records and
//   pure acks first pass the search word through tok0 and the cells, one cell a cycle
// throughput: one frame at a time, busy stays high until the result strobe
// reset: asynchronous active low; clears config to defaults, entry valid bits,
//   per-subflow state; the receiver cannot stall, each result shows for one cycle

module tcp_subflow_rtt_monitor (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rtm_pkg::rtm_in_t in_word_i,
  output logic                  res_strobe_o,
  output rtm_pkg::rtm_out_t     res_word_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_index_i,
  input  wire logic [47:0]      cfg_data_i
);
  import rtm_pkg::*;

  // configuration
  logic [15:0] proxy_q;
  logic [2:0]  active_q;
  logic [15:0] sfport_q [PortRegs];
  logic [47:0] age_q, gap_q;

  // per-subflow state
  logic [31:0] exp_q   [NumSubflows], exp_d   [NumSubflows];
  logic [7:0]  pc_q    [NumSubflows], pc_d    [NumSubflows];
  logic [47:0] srtt_q  [NumSubflows], srtt_d  [NumSubflows];
  logic [47:0] last_q  [NumSubflows], last_d  [NumSubflows];
  logic [47:0] bytes_q [NumSubflows], bytes_d [NumSubflows];

  rtm_state_e  state_q, state_d;
  rtm_in_t     in_q;
  logic        down_q, down_d;
  logic [SfW-1:0] sf_q, sf_d;
  rtm_tok_t    tok0_q, tok0_d;
  rtm_tok_t    tok [TableDepth+1];
  rtm_wr_t     wr;
  logic        res_strobe_q, res_strobe_d;
  rtm_out_t    res_q, res_d;

  // one cell per table row, each holding that row for every subflow
  assign tok[0] = tok0_q;
  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    rtm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(k)),
      .age_i      (age_q),
      .tok_i      (tok[k]),
      .wr_i       (wr),
      .tok_o      (tok[k+1])
    );
  end

  assign cfg_ready_o  = 1'b1;
  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_word_o   = res_q;

  // a before b within a half sequence window
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (b[31]) r = (a < b) && (a > (b - 32'h8000_0000));
    else       r = (a < b) || (a > (b + 32'h8000_0000));
    return r;
  endfunction

  // header parse, all from the latched frame
  logic        bad_hdr, bad_ip, bad_tcp, is_down, is_up, sf_found;
  logic [16:0] len17, opt20, plen0;
  logic [15:0] port_sel, plen;
  logic [5:0]  hlen;
  logic [2:0]  nsf;
  logic [SfW-1:0] sf_hit;
  logic [7:0]  pc_new;
  logic        do_cln;
  logic [31:0] end_seq;

  always_comb begin
    bad_hdr = (in_q.frame_len < 16'd14) || (in_q.ether_kind != EthIpv4) ||
              (in_q.ip_ver_ihl[7:4] != IpVersion) || (in_q.ip_ver_ihl[3:0] < 4'd5);
    len17   = {1'b0, in_q.frame_len} - 17'd14;
    opt20   = {11'd0, in_q.ip_ver_ihl[3:0] - 4'd5, 2'b00} + 17'd20;
    plen0   = {1'b0, in_q.ip_total_len} - opt20;
    bad_ip  = (len17 < {1'b0, in_q.ip_total_len}) ||
              ({1'b0, in_q.ip_total_len} < opt20) || (in_q.ip_proto != ProtoTcp) ||
              (plen0 < 17'd20);
    is_down = (in_q.src_port == proxy_q);
    is_up   = !is_down && (in_q.dst_port == proxy_q);
    port_sel = is_down ? in_q.dst_port : in_q.src_port;
    nsf     = (active_q > 3'(PortRegs)) ? 3'(PortRegs) : active_q;
    if (nsf > 3'(NumSubflows)) nsf = 3'(NumSubflows);
    sf_found = 1'b0;
    sf_hit   = '0;
    for (int i = PortRegs - 1; i >= 0; i--) begin
      if ((3'(i) < nsf) && (sfport_q[i] == port_sel)) begin
        sf_found = 1'b1;
        sf_hit   = SfW'(i);
      end
    end
    hlen    = {in_q.tcp_offset_byte[7:4], 2'b00};
    bad_tcp = ({11'd0, hlen} > plen0);
    plen    = plen0[15:0] - {10'd0, hlen};
    pc_new  = pc_q[sf_hit] + 8'd1;
    do_cln  = !pc_new[7] && (pc_new >= 8'(CleanupCount));
    end_seq = in_q.seq_num + {16'd0, plen};
  end

  // finish of a walk
  logic [47:0] sample, since, s7;
  logic [50:0] s7w;
  logic [47:0] ewma;

  always_comb begin
    sample = tok[TableDepth].now - tok[TableDepth].hit_time;
    since  = tok[TableDepth].now - last_q[sf_q];
    s7w    = {srtt_q[sf_q], 3'b000} - {3'b000, srtt_q[sf_q]};
    s7     = s7w[50:3];
    ewma   = s7 + {3'b000, sample[47:3]};
  end

  always_comb begin
    state_d      = state_q;
    down_d       = down_q;
    sf_d         = sf_q;
    tok0_d       = '0;
    wr           = '0;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    exp_d        = exp_q;
    pc_d         = pc_q;
    srtt_d       = srtt_q;
    last_d       = last_q;
    bytes_d      = bytes_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_PARSE;
      end
      S_PARSE: begin
        state_d      = S_IDLE;
        res_strobe_d = 1'b1;
        res_d        = '0;
        down_d       = is_down;
        sf_d         = sf_hit;
        priority if (bad_hdr || bad_ip) begin
          res_d.status = ST_MALFORMED;
        end else if (!is_down && !is_up) begin
          res_d.status = ST_NOT_PROXY;
        end else if (!sf_found) begin
          res_d.status = ST_UNKNOWN;
        end else if (bad_tcp) begin
          res_d.status = ST_MALFORMED;
        end else begin
          res_d.subflow       = sf_hit;
          res_d.smoothed_rtt  = srtt_q[sf_hit];
          res_d.payload_total = bytes_q[sf_hit];
          if (is_down) begin
            if ((plen == 16'd0) ||
                (seq_before(in_q.seq_num, exp_q[sf_hit]) && !pc_q[sf_hit][7])) begin
              res_d.status = ST_DOWN_SKIP;
            end else begin
              // record: bookkeeping now, table walk follows
              res_strobe_d   = 1'b0;
              state_d        = S_WALK;
              pc_d[sf_hit]   = do_cln ? 8'd0 : pc_new;
              exp_d[sf_hit]  = end_seq;
              bytes_d[sf_hit] = bytes_q[sf_hit] + {32'd0, plen};
              tok0_d.vld     = 1'b1;
              tok0_d.cln     = do_cln;
              tok0_d.sf      = sf_hit;
              tok0_d.key     = end_seq;
              tok0_d.now     = in_q.now_time;
            end
          end else begin
            if (plen != 16'd0) begin
              res_d.status = ST_UP_SKIP;
            end else begin
              res_strobe_d = 1'b0;
              state_d      = S_WALK;
              tok0_d.vld   = 1'b1;
              tok0_d.sf    = sf_hit;
              tok0_d.key   = in_q.ack_num;
              tok0_d.now   = in_q.now_time;
            end
          end
        end
      end
      S_WALK: begin
        if (tok[TableDepth].vld) begin
          state_d      = S_IDLE;
          res_strobe_d = 1'b1;
          res_d        = '0;
          res_d.subflow = sf_q;
          res_d.payload_total = bytes_q[sf_q];
          res_d.smoothed_rtt  = srtt_q[sf_q];
          wr.sf     = sf_q;
          wr.seq    = tok[TableDepth].key;
          wr.time_v = tok[TableDepth].now;
          if (down_q) begin
            // an equal end sequence wins over the first free row
            priority if (tok[TableDepth].hit) begin
              wr.set = 1'b1;
              wr.idx = tok[TableDepth].hit_idx;
              res_d.status = ST_DOWN_REC;
            end else if (tok[TableDepth].free) begin
              wr.set = 1'b1;
              wr.idx = tok[TableDepth].free_idx;
              res_d.status = ST_DOWN_REC;
            end else begin
              res_d.status = ST_FULL;
            end
          end else begin
            if (tok[TableDepth].hit) begin
              wr.clr = 1'b1;
              wr.idx = tok[TableDepth].hit_idx;
              srtt_d[sf_q] = (since > gap_q) ? sample : ewma;
              if (srtt_d[sf_q] == 48'd0) srtt_d[sf_q] = 48'd1;
              last_d[sf_q] = tok[TableDepth].now;
              res_d.status       = ST_RTT_UPD;
              res_d.rtt_sample   = sample;
              res_d.smoothed_rtt = srtt_d[sf_q];
            end else begin
              res_d.status = ST_UP_SKIP;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_strobe_q <= 1'b0;
      tok0_q       <= '0;
      proxy_q      <= '0;
      active_q     <= 3'd1;
      age_q        <= 48'd1000000;
      gap_q        <= 48'd1000000;
      for (int i = 0; i < PortRegs; i++) sfport_q[i] <= '0;
      for (int i = 0; i < NumSubflows; i++) begin
        exp_q[i]   <= '0;
        pc_q[i]    <= 8'hFF;
        srtt_q[i]  <= '0;
        last_q[i]  <= '0;
        bytes_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      res_strobe_q <= res_strobe_d;
      tok0_q       <= tok0_d;
      exp_q        <= exp_d;
      pc_q         <= pc_d;
      srtt_q       <= srtt_d;
      last_q       <= last_d;
      bytes_q      <= bytes_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_PROXY_PORT: proxy_q     <= cfg_data_i[15:0];
          REG_ACTIVE_SF:  active_q    <= cfg_data_i[2:0];
          REG_PORT_A:     sfport_q[0] <= cfg_data_i[15:0];
          REG_PORT_B:     sfport_q[1] <= cfg_data_i[15:0];
          REG_PORT_C:     sfport_q[2] <= cfg_data_i[15:0];
          REG_PORT_D:     sfport_q[3] <= cfg_data_i[15:0];
          REG_CLN_AGE:    age_q       <= cfg_data_i;
          REG_RTT_GAP:    gap_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) in_q <= in_word_i;
    down_q <= down_d;
    sf_q   <= sf_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rtm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtm_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [rtm_pkg::IdxW-1:0] cell_idx_i,
  input  wire logic [47:0]             age_i,
  input  wire rtm_pkg::rtm_tok_t       tok_i,
  input  wire rtm_pkg::rtm_wr_t        wr_i,
  output rtm_pkg::rtm_tok_t            tok_o
);
  import rtm_pkg::*;

  logic [31:0]            seq_q  [NumSubflows];
  logic [47:0]            time_q [NumSubflows];
  logic [NumSubflows-1:0] valid_q;
  rtm_tok_t               tok_q, tok_d;

  logic cur_v, aged, v_post, match, wr_me;

  always_comb begin
    cur_v  = valid_q[tok_i.sf];
    aged   = tok_i.cln && cur_v &&
             ({1'b0, tok_i.now} > ({1'b0, age_i} + {1'b0, time_q[tok_i.sf]}));
    v_post = cur_v && !aged;
    match  = v_post && (seq_q[tok_i.sf] == tok_i.key);
    wr_me  = (wr_i.idx == cell_idx_i);
    tok_d  = tok_i;
    if (tok_i.vld) begin
      if (!tok_i.hit && match) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_idx  = cell_idx_i;
        tok_d.hit_time = time_q[tok_i.sf];
      end
      if (!tok_i.free && !v_post) begin
        tok_d.free     = 1'b1;
        tok_d.free_idx = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld && aged) valid_q[tok_i.sf] <= 1'b0;
      if (wr_i.set && wr_me) valid_q[wr_i.sf] <= 1'b1;
      if (wr_i.clr && wr_me) valid_q[wr_i.sf] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set && wr_me) begin
      seq_q[wr_i.sf]  <= wr_i.seq;
      time_q[wr_i.sf] <= wr_i.time_v;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== bench/tcp_subflow_rtt_monitor_tb.sv =====
`timescale 1ns / 1ps

module tcp_subflow_rtt_monitor_tb;
  import rtm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int Settle     = 24;  // beyond the table walk

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rtm_in_t  in_word;
  logic     res_strobe;
  rtm_out_t res_word;
  logic     cfg_valid;
  logic     cfg_ready;
  rtm_reg_e cfg_index;
  logic [47:0] cfg_data;

  tcp_subflow_rtt_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word),
    .res_strobe_o(res_strobe),
    .res_word_o  (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // shadow copy of the register file
  logic [15:0] sh_proxy;
  logic [2:0]  sh_active;
  logic [15:0] sh_port [4];
  logic [47:0] sh_age;
  logic [47:0] sh_gap;

  // shadow copy of the per-subflow tables and counters
  logic [31:0] tab_seq  [NumSubflows*TableDepth];
  logic [47:0] tab_time [NumSubflows*TableDepth];
  logic        tab_vld  [NumSubflows*TableDepth];
  logic [31:0] next_seq [NumSubflows];
  logic [7:0]  seg_count[NumSubflows];
  logic [47:0] srtt     [NumSubflows];
  logic [47:0] last_smp [NumSubflows];
  logic [47:0] dl_bytes [NumSubflows];

  rtm_out_t exp_q[$];
  int       fails;
  int       cycles;

  // sequence a lies behind b within half the sequence space
  function automatic bit seq_behind(logic [31:0] a, logic [31:0] b);
    if (b >= 32'h8000_0000) return (a < b) && (a > b - 32'h8000_0000);
    return (a < b) || (a > b + 32'h8000_0000);
  endfunction

  function automatic rtm_out_t fill(rtm_status_e st, int sf, logic [47:0] smp);
    rtm_out_t r;
    r = '0;
    r.status     = st;
    r.rtt_sample = smp;
    if (st >= ST_DOWN_SKIP) begin
      r.subflow       = sf[1:0];
      r.smoothed_rtt  = srtt[sf];
      r.payload_total = dl_bytes[sf];
    end
    return r;
  endfunction

  // works out the result word of one frame and updates the shadow state
  function automatic rtm_out_t monitor_frame(rtm_in_t w);
    logic [63:0] avail, opt, pay, hl, tot;
    logic [15:0] cport;
    logic        down;
    logic [31:0] seg_end;
    logic [47:0] smp;
    int          nsf, sf, slot, base;
    sf = -1;
    slot = -1;
    tot = 64'(w.ip_total_len);
    if (w.frame_len < 14 || w.ether_kind != EthIpv4 || w.ip_ver_ihl[7:4] != IpVersion
        || w.ip_ver_ihl[3:0] < 5)
      return fill(ST_MALFORMED, 0, '0);
    avail = 64'(w.frame_len) - 14;
    opt   = 4 * (64'(w.ip_ver_ihl[3:0]) - 5);
    if (avail < tot || tot < opt + 20 || w.ip_proto != ProtoTcp || tot - opt - 20 < 20)
      return fill(ST_MALFORMED, 0, '0);
    pay = tot - opt - 20;
    if (w.src_port == sh_proxy) begin
      down = 1'b1;
      cport = w.dst_port;
    end else if (w.dst_port == sh_proxy) begin
      down = 1'b0;
      cport = w.src_port;
    end else begin
      return fill(ST_NOT_PROXY, 0, '0);
    end
    nsf = (sh_active > 4) ? 4 : int'(sh_active);
    for (int i = nsf - 1; i >= 0; i--)
      if (sh_port[i] == cport) sf = i;
    if (sf < 0) return fill(ST_UNKNOWN, 0, '0);
    hl = 64'(w.tcp_offset_byte[7:4]) * 4;
    if (hl > pay) return fill(ST_MALFORMED, 0, '0);
    pay = pay - hl;
    base = sf * TableDepth;
    if (down) begin
      if (pay == 0 || (seq_behind(w.seq_num, next_seq[sf]) && seg_count[sf] < 8'h80))
        return fill(ST_DOWN_SKIP, sf, '0);
      seg_count[sf] = seg_count[sf] + 8'd1;
      if (seg_count[sf] < 8'h80 && seg_count[sf] >= CleanupCount) begin
        for (int i = 0; i < TableDepth; i++)
          if (tab_vld[base+i] && 64'(w.now_time) > 64'(sh_age) + 64'(tab_time[base+i]))
            tab_vld[base+i] = 1'b0;
        seg_count[sf] = '0;
      end
      seg_end = w.seq_num + pay[31:0];
      next_seq[sf] = seg_end;
      dl_bytes[sf] = dl_bytes[sf] + pay[47:0];
      for (int i = TableDepth - 1; i >= 0; i--)
        if (tab_vld[base+i] && tab_seq[base+i] == seg_end) slot = i;
      if (slot < 0)
        for (int i = TableDepth - 1; i >= 0; i--)
          if (!tab_vld[base+i]) slot = i;
      if (slot < 0) return fill(ST_FULL, sf, '0);
      tab_seq[base+slot]  = seg_end;
      tab_time[base+slot] = w.now_time;
      tab_vld[base+slot]  = 1'b1;
      return fill(ST_DOWN_REC, sf, '0);
    end
    if (pay > 0) return fill(ST_UP_SKIP, sf, '0);
    for (int i = TableDepth - 1; i >= 0; i--)
      if (tab_vld[base+i] && tab_seq[base+i] == w.ack_num) slot = i;
    if (slot < 0) return fill(ST_UP_SKIP, sf, '0);
    smp = w.now_time - tab_time[base+slot];
    tab_vld[base+slot] = 1'b0;
    if (w.now_time - last_smp[sf] > sh_gap) srtt[sf] = smp;
    else srtt[sf] = 48'((64'(srtt[sf]) * 7) / 8 + 64'(smp) / 8);
    if (srtt[sf] == '0) srtt[sf] = 48'd1;
    last_smp[sf] = w.now_time;
    return fill(ST_RTT_UPD, sf, smp);
  endfunction

  // well-formed frame towards (down) or from the client port
  function automatic rtm_in_t tcp_frame(bit down, logic [15:0] cport, logic [31:0] seq,
                                        logic [31:0] ack, int pay, logic [47:0] t);
    rtm_in_t w;
    w.ether_kind      = EthIpv4;
    w.ip_ver_ihl      = 8'h45;
    w.ip_proto        = ProtoTcp;
    w.ip_total_len    = 16'(40 + pay);
    w.frame_len       = 16'(54 + pay + $urandom_range(0, 7));
    w.src_port        = down ? sh_proxy : cport;
    w.dst_port        = down ? cport : sh_proxy;
    w.tcp_offset_byte = {4'h5, 4'($urandom)};
    w.seq_num         = seq;
    w.ack_num         = ack;
    w.now_time        = t;
    return w;
  endfunction

  // one word on the frame port; start is left high for the caller
  task automatic send_frame(rtm_in_t w, bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (busy);
    exp_q.push_back(monitor_frame(w));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  // cfg_valid stays high across a burst and drops once it ends
  task automatic write_reg(rtm_reg_e idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_PROXY_PORT: sh_proxy = val[15:0];
      REG_ACTIVE_SF:  sh_active = val[2:0];
      REG_PORT_A:     sh_port[0] = val[15:0];
      REG_PORT_B:     sh_port[1] = val[15:0];
      REG_PORT_C:     sh_port[2] = val[15:0];
      REG_PORT_D:     sh_port[3] = val[15:0];
      REG_CLN_AGE:    sh_age = val;
      REG_RTT_GAP:    sh_gap = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [15:0] px, logic [2:0] act, logic [15:0] pa,
                            logic [15:0] pb, logic [15:0] pc, logic [15:0] pd,
                            logic [47:0] age, logic [47:0] gap);
    wait_idle();
    write_reg(REG_PROXY_PORT, 48'(px));
    write_reg(REG_ACTIVE_SF, 48'(act));
    write_reg(REG_PORT_A, 48'(pa));
    write_reg(REG_PORT_B, 48'(pb));
    write_reg(REG_PORT_C, 48'(pc));
    write_reg(REG_PORT_D, 48'(pd));
    write_reg(REG_CLN_AGE, age);
    write_reg(REG_RTT_GAP, gap);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    rtm_out_t e;
    if (rst_ni && res_strobe) begin
      if (exp_q.size() == 0) begin
        $error("result word with nothing expected: %p", res_word);
        fails++;
      end else begin
        e = exp_q.pop_front();
        if (res_word.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res_word.status);
          fails++;
        end
        if (res_word.subflow !== e.subflow) begin
          $error("subflow: expected %0d, got %0d", e.subflow, res_word.subflow);
          fails++;
        end
        if (res_word.rtt_sample !== e.rtt_sample) begin
          $error("rtt_sample: expected %0h, got %0h", e.rtt_sample, res_word.rtt_sample);
          fails++;
        end
        if (res_word.smoothed_rtt !== e.smoothed_rtt) begin
          $error("smoothed_rtt: expected %0h, got %0h", e.smoothed_rtt,
                 res_word.smoothed_rtt);
          fails++;
        end
        if (res_word.payload_total !== e.payload_total) begin
          $error("payload_total: expected %0h, got %0h", e.payload_total,
                 res_word.payload_total);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    rtm_in_t     w;
    bit          typed;
    rtm_status_e st;
  } dir_row_t;

  dir_row_t    dir_rows[$];
  logic [47:0] now_t;

  function automatic void add_row(rtm_in_t w, bit typed, rtm_status_e st);
    dir_row_t r;
    r.w = w;
    r.typed = typed;
    r.st = st;
    dir_rows.push_back(r);
  endfunction

  // one random frame, mostly well formed flows with some noise
  function automatic rtm_in_t random_frame();
    rtm_in_t w;
    int      pick, nact, sfi, slot, pay;
    logic [31:0] seq, ack;
    logic [255:0] rnd;
    pick = $urandom_range(0, 99);
    nact = (sh_active == 0) ? 1 : ((sh_active > 4) ? 4 : int'(sh_active));
    sfi  = $urandom_range(0, nact - 1);
    now_t = now_t + 48'($urandom_range(0, 3000));
    if (pick < 45) begin
      seq = next_seq[sfi];
      if ($urandom_range(0, 7) == 0) seq = seq - $urandom_range(1, 3000);
      pay = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1460);
      w = tcp_frame(1'b1, sh_port[sfi], seq, $urandom, pay, now_t);
    end else if (pick < 78) begin
      slot = sfi * TableDepth + $urandom_range(0, TableDepth - 1);
      ack = tab_vld[slot] ? tab_seq[slot] : $urandom;
      w = tcp_frame(1'b0, sh_port[sfi], $urandom, ack, 0, now_t);
    end else if (pick < 85) begin
      w = tcp_frame(1'b0, sh_port[sfi], $urandom, next_seq[sfi],
                    $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 100), now_t);
    end else begin
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      w = rnd[$bits(rtm_in_t)-1:0];
      if (pick < 93) begin
        w.ether_kind = EthIpv4;
        w.ip_ver_ihl = {IpVersion, 4'($urandom_range(5, 15))};
      end
    end
    return w;
  endfunction

  initial begin
    rtm_in_t w;
    rtm_out_t chk;
    int       n_items [5];
    fails     = 0;
    cycles    = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PROXY_PORT;
    cfg_data  = '0;
    // register defaults after reset
    sh_proxy  = '0;
    sh_active = 3'd1;
    sh_age    = 48'd1000000;
    sh_gap    = 48'd1000000;
    for (int i = 0; i < 4; i++) sh_port[i] = '0;
    for (int i = 0; i < NumSubflows * TableDepth; i++) begin
      tab_vld[i] = 1'b0;
      tab_seq[i] = '0;
      tab_time[i] = '0;
    end
    for (int i = 0; i < NumSubflows; i++) begin
      next_seq[i] = '0;
      seg_count[i] = 8'hFF;
      srtt[i] = '0;
      last_smp[i] = '0;
      dl_bytes[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first frame under reset defaults: proxy port 0, subflow port 0 both sides
    w = tcp_frame(1'b1, 16'd0, 32'd0, 32'd0, 0, 48'd0);
    send_frame(w, 1'b0);

    // duplicate port on subflow d, short age and gap
    set_config(16'd80, 3'd4, 16'd1000, 16'd1001, 16'd1002, 16'd1000, 48'd500, 48'd300);

    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.ether_kind = 16'h86DD;
    add_row(w, 1'b1, ST_MALFORMED);
    w.ether_kind = EthIpv4;
    w.frame_len = '0;
    add_row(w, 1'b1, ST_MALFORMED);
    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.ip_ver_ihl = 8'h65;
    add_row(w, 1'b1, ST_MALFORMED);
    w.ip_ver_ihl = 8'h44;
    add_row(w, 1'b1, ST_MALFORMED);
    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.ip_total_len = w.frame_len;
    add_row(w, 1'b1, ST_MALFORMED);
    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.ip_proto = 8'd17;
    add_row(w, 1'b1, ST_MALFORMED);
    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.src_port = 16'd81;
    add_row(w, 1'b1, ST_NOT_PROXY);
    add_row(tcp_frame(1'b1, 16'd1003, 32'd1, 32'd0, 10, 48'd10), 1'b1, ST_UNKNOWN);
    // data offset reaching past the ip payload
    w = tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 10, 48'd10);
    w.tcp_offset_byte = 8'hF0;
    add_row(w, 1'b1, ST_MALFORMED);
    add_row(tcp_frame(1'b1, 16'd1000, 32'd1, 32'd0, 0, 48'd20), 1'b1, ST_DOWN_SKIP);
    add_row(tcp_frame(1'b1, 16'd1000, 32'd100, 32'd0, 100, 48'd1000), 1'b1, ST_DOWN_REC);
    // retransmission of the same segment
    add_row(tcp_frame(1'b1, 16'd1000, 32'd100, 32'd0, 100, 48'd1010), 1'b1, ST_DOWN_SKIP);
    add_row(tcp_frame(1'b0, 16'd1000, 32'd7, 32'd200, 0, 48'd1040), 1'b1, ST_RTT_UPD);
    add_row(tcp_frame(1'b0, 16'd1000, 32'd7, 32'd200, 5, 48'd1050), 1'b1, ST_UP_SKIP);
    add_row(tcp_frame(1'b0, 16'd1000, 32'd7, 32'd999, 0, 48'd1060), 1'b1, ST_UP_SKIP);
    add_row(tcp_frame(1'b1, 16'd1000, 32'd200, 32'd0, 1, 48'd1070), 1'b1, ST_DOWN_REC);
    add_row(tcp_frame(1'b1, 16'd1000, 32'd200, 32'd0, 1, 48'd1080), 1'b0, ST_DOWN_REC);
    // sequence and time wrap on subflow b
    add_row(tcp_frame(1'b1, 16'd1001, 32'hFFFF_FFF0, 32'd0, 32, 48'hFFFF_FFFF_FFF0),
            1'b1, ST_DOWN_REC);
    add_row(tcp_frame(1'b0, 16'd1001, 32'd0, 32'h10, 0, 48'h10), 1'b1, ST_RTT_UPD);
    // longest ip header with options
    w = tcp_frame(1'b1, 16'd1002, 32'd5, 32'd0, 10, 48'd2000);
    w.ip_ver_ihl = 8'h4F;
    w.ip_total_len = w.ip_total_len + 16'd40;
    w.frame_len = w.frame_len + 16'd40;
    add_row(w, 1'b1, ST_DOWN_REC);
    // data offset below five words is taken as is
    w = tcp_frame(1'b1, 16'd1002, 32'd15, 32'd0, 10, 48'd2100);
    w.tcp_offset_byte = 8'h0F;
    add_row(w, 1'b1, ST_DOWN_REC);
    add_row('1, 1'b1, ST_MALFORMED);

    foreach (dir_rows[k]) begin
      send_frame(dir_rows[k].w, 1'b1);
      chk = exp_q[$];
      if (dir_rows[k].typed && chk.status != dir_rows[k].st) begin
        $error("status: expected %0d, got %0d", dir_rows[k].st, chk.status);
        fails++;
      end
    end

    // random phases, each with its own register setting
    n_items = '{210, 210, 210, 40, 200};
    now_t = 48'd5000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(16'd443, 3'd4, 16'd5001, 16'd5002, 16'd5003, 16'd5004,
                      48'd40000, 48'd20000);
        1: set_config(16'd0, 3'd2, 16'd0, 16'hFFFF, 16'd7, 16'd7, 48'd0, 48'd0);
        2: set_config(16'hFFFF, 3'd7, 16'd9, 16'd9, 16'd10, 16'd11,
                      48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        3: set_config(16'd8080, 3'd0, 16'd1, 16'd2, 16'd3, 16'd4, 48'd1000, 48'd1000);
        default: set_config(16'd8080, 3'd3, 16'd1, 16'd2, 16'd3, 16'd4,
                            48'd1000000, 48'd1000000);
      endcase
      for (int k = 0; k < n_items[ph]; k++)
        send_frame(random_frame(), !(ph == 4 && k >= 120));
    end

    start <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
